@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, held off while reset is active.
`define ASSERT_CLKED(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Plain condition that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	`ASSERT_CLKED(label, clk, rst_n, (1'b1 |-> (cond)), msg)

`endif

@@ rtl/spc_pkg.sv @@
package spc_pkg;

	// Depth of the mark store and the largest limit honoured.
	localparam int unsigned MAX_LIMIT = 65536;
	localparam int unsigned ADDR_W    = $clog2(MAX_LIMIT);
	localparam int unsigned LIMIT_W   = 17;
	localparam int unsigned COUNT_W   = 17;
	localparam int unsigned DATA_W    = ((LIMIT_W + 7) / 8) * 8;

	localparam logic [LIMIT_W-1:0] LIMIT_SAT = LIMIT_W'(MAX_LIMIT);
	localparam logic [LIMIT_W-1:0] FIRST_CANDIDATE = LIMIT_W'(2);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK,
		ST_DONE
	} state_t;

	// One access to the mark store per cycle from the sequencer.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

@@ rtl/spc_mark_ram.sv @@
module spc_mark_ram
	import spc_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output logic     rd_data
);

	// One bit per number: set means known composite.
	logic mark_mem [MAX_LIMIT];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mark_mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mark_mem[req.rd_addr];
		end
	end

endmodule

@@ rtl/spc_ctrl.sv @@
module spc_ctrl
	import spc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  logic [LIMIT_W-1:0] job_limit,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [COUNT_W-1:0] res_count,
	output mem_req_t           mem_req,
	input  logic               mem_rd_data
);

	state_t             state_q, state_d;
	logic [LIMIT_W-1:0] lim_q, lim_d;
	logic [LIMIT_W-1:0] cand_q, cand_d;
	logic [LIMIT_W-1:0] addr_q, addr_d;
	logic [COUNT_W-1:0] count_q, count_d;

	// State and job registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lim_q   <= '0;
			cand_q  <= '0;
			addr_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			lim_q   <= lim_d;
			cand_q  <= cand_d;
			addr_q  <= addr_d;
			count_q <= count_d;
		end
	end

	// Next state, counters and store accesses.
	always_comb begin
		state_d   = state_q;
		lim_d     = lim_q;
		cand_d    = cand_q;
		addr_d    = addr_q;
		count_d   = count_q;
		job_ready = 1'b0;
		res_valid = 1'b0;
		mem_req   = '0;

		unique case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					lim_d   = (job_limit > LIMIT_SAT) ? LIMIT_SAT : job_limit;
					addr_d  = FIRST_CANDIDATE;
					cand_d  = FIRST_CANDIDATE;
					count_d = '0;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				// Clear the marks from two up to, not including, the limit, one per cycle.
				if (addr_q >= lim_q) begin
					state_d = ST_SCAN_RD;
				end else begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = addr_q[ADDR_W-1:0];
					mem_req.wr_data = 1'b0;
					addr_d          = addr_q + LIMIT_W'(1);
				end
			end
			ST_SCAN_RD: begin
				// Fetch the mark of the next candidate.
				if (cand_q >= lim_q) begin
					state_d = ST_DONE;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = cand_q[ADDR_W-1:0];
					state_d         = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				// An unmarked candidate is prime: count it and strike its multiples.
				if (!mem_rd_data) begin
					count_d = count_q + COUNT_W'(1);
					addr_d  = cand_q + cand_q;
					state_d = ST_MARK;
				end else begin
					cand_d  = cand_q + LIMIT_W'(1);
					state_d = ST_SCAN_RD;
				end
			end
			ST_MARK: begin
				if (addr_q >= lim_q) begin
					cand_d  = cand_q + LIMIT_W'(1);
					state_d = ST_SCAN_RD;
				end else begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = addr_q[ADDR_W-1:0];
					mem_req.wr_data = 1'b1;
					addr_d          = addr_q + cand_q;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_count = count_q;

endmodule

@@ rtl/sieve_prime_counter.sv @@
// Counts the primes strictly below the limit carried by each input beat, by a
// Sieve of Eratosthenes over a one-bit-per-number store, and returns one
// result beat per job. A limit above 65536 is treated as 65536, and a limit
// of two or less gives zero. Jobs run one at a time; each clears the store,
// then reads and checks the mark of each number scanned, strikes out each
// multiple of each prime found and ends each prime's marking pass. The
// sequencer makes one read or one write to the mark store per cycle. A
// finished result waits in an output register, so the next job is taken
// while it is still unread.
module sieve_prime_counter
	import spc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // [16:0] limit, rest zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata   // [16:0] prime_count, rest zero
);

	mem_req_t           mem_req;
	logic               mem_rd_data;
	logic               res_valid;
	logic               res_ready;
	logic [COUNT_W-1:0] res_count;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;

	spc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (s_tvalid),
		.job_ready   (s_tready),
		.job_limit   (s_tdata[LIMIT_W-1:0]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_count   (res_count),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	spc_mark_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	// Output register: loads when empty or being emptied this cycle.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_count_q <= res_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(DATA_W-COUNT_W){1'b0}}, out_count_q};

endmodule

@@ rtl/spc_checker.sv @@
`include "assert_macros.svh"

module spc_checker
	import spc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// A waiting result beat stays until taken.
	`ASSERT_CLKED(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")

	// The pad bits above the count are zero on every valid result beat.
	`ASSERT_ALWAYS(a_out_pad, clk, arst_n, !m_tvalid || (m_tdata[DATA_W-1:COUNT_W] == '0), "nonzero pad bits")

	// No more primes than half the largest limit.
	`ASSERT_ALWAYS(a_count_range, clk, arst_n, !m_tvalid || (m_tdata[COUNT_W-1:0] <= COUNT_W'(MAX_LIMIT / 2)), "prime count out of range")

	// After taking a job the block is busy with it and takes no other.
	`ASSERT_CLKED(a_busy_after_job, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second job taken while busy")

endmodule

bind sieve_prime_counter spc_checker u_spc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
